### hw/rtl/vector2d_length_clamp_macros.svh
// Assertion macros for the vector length clamp block.
// Used by vector2d_length_clamp.sv; needs clk_i and rst_ni in the including scope.
`ifndef VECTOR2D_LENGTH_CLAMP_MACROS_SVH
`define VECTOR2D_LENGTH_CLAMP_MACROS_SVH

// Clocked implication, checked outside reset.
`define V2LC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never hold outside reset.
`define V2LC_NEVER(lbl, cond, msg) \
  `V2LC_ASSERT(lbl, !(cond), msg)

`endif

### hw/rtl/v2lc_pkg.sv
// Shared types, codes and arithmetic steps of the vector length clamp.
// No dependencies; imported by vector2d_length_clamp.
`timescale 1ns / 1ps

package v2lc_pkg;

  localparam int unsigned NumStages = 21;
  localparam logic [15:0] QOne      = 16'd256;
  localparam logic [15:0] MaxLenRst = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_CLAMP     = 2'd0,
    OP_NORMALIZE = 2'd1,
    OP_TRUNCATE  = 2'd2,
    OP_PASS      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_MIN_LENGTH     = 2'd0,
    REG_MAX_LENGTH     = 2'd1,
    REG_ZERO_TOLERANCE = 2'd2,
    REG_NONE           = 2'd3
  } reg_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               tz;
    logic [30:0]        sqx;
    logic [30:0]        sqy;
    logic [31:0]        lsq;
    logic [31:0]        rem;
    logic [31:0]        root;
    logic               scale;
    logic               zero;
    logic [15:0]        tgt;
    logic [31:0]        nx;
    logic [31:0]        ny;
    logic               ovx;
    logic               ovy;
    logic [16:0]        qx;
    logic [16:0]        qy;
  } pipe_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               sat;
  } res_t;

  function automatic logic [16:0] abs17(logic signed [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    return v[15] ? (17'd0 - e) : e;
  endfunction

  // One digit of the shift-and-subtract square root.
  function automatic sq_t sqrt_step(sq_t s, int unsigned j);
    sq_t         r;
    logic [31:0] b;
    logic [31:0] t;
    b = 32'd1 << (30 - 2 * j);
    t = s.root + b;
    if (s.rem >= t) begin
      r.rem  = s.rem - t;
      r.root = (s.root >> 1) + b;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // One quotient bit of restoring division; bit 32 of the result is that bit.
  function automatic logic [32:0] div_step(logic [31:0] rem, logic [15:0] len,
                                           int unsigned i);
    logic [32:0] sh;
    sh = {17'd0, len} << i;
    if ({1'b0, rem} >= sh) begin
      return {1'b1, rem - sh[31:0]};
    end
    return {1'b0, rem};
  endfunction

  // Sign and saturation of one quotient magnitude; bit 16 is the flag.
  function automatic logic [16:0] sat_comp(logic neg, logic ov, logic [16:0] q);
    logic [16:0] nq;
    nq = 17'd0 - q;
    if (!neg) begin
      if (ov || q > 17'd32767) begin
        return {1'b1, 16'h7FFF};
      end
      return {1'b0, q[15:0]};
    end
    if (ov || q > 17'd32768) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, nq[15:0]};
  endfunction

endpackage

### hw/rtl/vector2d_length_clamp.sv
// Results pass from the last pipeline stage into the output register.
// Throughput: one vector per cycle while the skid register is empty; every stage holds one item.
// Depth is set by the 16-digit square root (two digits per stage) and the
// 17-bit restoring divider (two quotient bits per stage).
// Reset (rst_ni low, asynchronous) empties the pipeline and loads
// min_length = 0, max_length = 65535, zero_tolerance = 0.
`timescale 1ns / 1ps

// Pipelined 2D vector clamp, normalize and truncate in signed Q8.8.
// Depends on v2lc_pkg and vector2d_length_clamp_macros.svh.
`include "vector2d_length_clamp_macros.svh"

module vector2d_length_clamp
  import v2lc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] x_in, [31:16] y_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] x_out, [31:16] y_out, [32] saturated
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The squared bounds are refreshed every cycle;
  // the user must change registers only while the pipeline is empty; the block
  // does not enforce this. Then no item sees stale squared bounds.
  // ---------------------------------------------------------------------------
  logic [15:0] min_len_q, max_len_q, tol_q;
  logic [31:0] minsq_q, maxsq_q;
  reg_e        wr_idx;

  assign pready = 1'b1;
  assign wr_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= 16'd0;
      max_len_q <= MaxLenRst;
      tol_q     <= 16'd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (wr_idx)
        REG_MIN_LENGTH:     min_len_q <= pwdata[15:0];
        REG_MAX_LENGTH:     max_len_q <= pwdata[15:0];
        REG_ZERO_TOLERANCE: tol_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    minsq_q <= min_len_q * min_len_q;
    maxsq_q <= max_len_q * max_len_q;
  end

  always_comb begin
    unique case (wr_idx)
      REG_MIN_LENGTH:     prdata = {16'd0, min_len_q};
      REG_MAX_LENGTH:     prdata = {16'd0, max_len_q};
      REG_ZERO_TOLERANCE: prdata = {16'd0, tol_q};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath pipeline. All stages move together while the skid register is
  // empty; a blocked output only stalls the pipe once the skid is full, so the
  // next transfer is taken while a finished result waits.
  // Stage map:
  //   0      capture
  //   1      squares, zero-tolerance test
  //   2      squared length
  //   3      operation decision, target length
  //   4      |c| * target, root digits 0..1
  //   5..11  root digits 2..15
  //   12     overflow test of the quotients
  //   13..20 quotient bits 16..1
  //   output quotient bit 0, sign and saturation
  // ---------------------------------------------------------------------------
  logic  en;
  logic  v_q [NumStages];
  pipe_t st_q [NumStages];
  pipe_t st_d [NumStages];

  logic  out_v_q, skid_v_q;
  res_t  out_q, skid_q, fin;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  always_comb begin
    sq_t         sq;
    logic [32:0] dx, dy;
    logic [32:0] prx, pry;
    logic [33:0] px2, py2;
    logic [16:0] ax, ay;
    logic [15:0] len;
    pipe_t       p;
    int unsigned j;
    for (int k = 0; k < NumStages; k++) begin
      if (k == 0) begin
        p    = '0;
        p.op = op_e'(s_axis_tuser);
        p.x  = s_axis_tdata[15:0];
        p.y  = s_axis_tdata[31:16];
      end else begin
        p = st_q[k-1];
      end
      ax  = abs17(p.x);
      ay  = abs17(p.y);
      len = p.root[15:0];
      if (k == 1) begin
        px2   = ax * ax;
        py2   = ay * ay;
        p.sqx = px2[30:0];
        p.sqy = py2[30:0];
        p.tz  = (ax <= {1'b0, tol_q}) && (ay <= {1'b0, tol_q});
      end else if (k == 2) begin
        p.lsq = {1'b0, p.sqx} + {1'b0, p.sqy};
      end else if (k == 3) begin
        p.scale = 1'b0;
        p.zero  = 1'b0;
        p.tgt   = 16'd0;
        p.rem   = p.lsq;
        p.root  = 32'd0;
        unique case (p.op)
          OP_CLAMP: begin
            if (p.lsq != 32'd0) begin
              priority if (p.lsq < minsq_q) begin
                p.scale = 1'b1;
                p.tgt   = min_len_q;
              end else if (p.lsq > maxsq_q) begin
                p.scale = 1'b1;
                p.tgt   = max_len_q;
              end
            end
          end
          OP_NORMALIZE: begin
            if (p.lsq == 32'd0) begin
              p.zero = 1'b1;
            end else begin
              p.scale = 1'b1;
              p.tgt   = QOne;
            end
          end
          OP_TRUNCATE: begin
            priority if (max_len_q == 16'd0 || p.tz) begin
              p.zero = 1'b1;
            end else if (p.lsq > maxsq_q) begin
              p.scale = 1'b1;
              p.tgt   = max_len_q;
            end
          end
          default: ;
        endcase
      end else if (k >= 4 && k <= 11) begin
        if (k == 4) begin
          prx  = ax * p.tgt;
          pry  = ay * p.tgt;
          p.nx = prx[31:0];
          p.ny = pry[31:0];
        end
        j  = 32'(2 * (k - 4));
        sq = sqrt_step({p.rem, p.root}, j);
        sq = sqrt_step(sq, j + 1);
        p.rem  = sq.rem;
        p.root = sq.root;
      end else if (k == 12) begin
        p.ovx = {1'b0, p.nx[31:17]} >= len;
        p.ovy = {1'b0, p.ny[31:17]} >= len;
        p.qx  = 17'd0;
        p.qy  = 17'd0;
      end else if (k >= 13) begin
        j  = 32'(16 - 2 * (k - 13));
        dx = div_step(p.nx, len, j);
        dy = div_step(p.ny, len, j);
        p.qx[j] = dx[32];
        p.qy[j] = dy[32];
        dx = div_step(dx[31:0], len, j - 1);
        dy = div_step(dy[31:0], len, j - 1);
        p.qx[j-1] = dx[32];
        p.qy[j-1] = dy[32];
        p.nx = dx[31:0];
        p.ny = dy[31:0];
      end
      st_d[k] = p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumStages; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NumStages; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NumStages; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Last quotient bit, then sign, saturation and result selection.
  always_comb begin
    pipe_t       p;
    logic [32:0] dx, dy;
    logic [16:0] qx, qy, cx, cy;
    p  = st_q[NumStages-1];
    dx = div_step(p.nx, p.root[15:0], 0);
    dy = div_step(p.ny, p.root[15:0], 0);
    qx = {p.qx[16:1], dx[32]};
    qy = {p.qy[16:1], dy[32]};
    cx = sat_comp(p.x[15], p.ovx, qx);
    cy = sat_comp(p.y[15], p.ovy, qy);
    priority if (p.scale) begin
      fin.x   = cx[15:0];
      fin.y   = cy[15:0];
      fin.sat = cx[16] | cy[16];
    end else if (p.zero) begin
      fin = '0;
    end else begin
      fin.x   = p.x;
      fin.y   = p.y;
      fin.sat = 1'b0;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= v_q[NumStages-1];
    end else if (v_q[NumStages-1]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || m_axis_tready) begin
      out_q <= fin;
    end else begin
      skid_q <= fin;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, out_q.sat, out_q.y, out_q.x};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `V2LC_NEVER(a_skid_needs_out, skid_v_q && !out_v_q, "skid full while output empty")
  `V2LC_ASSERT(a_skid_drains, skid_v_q && m_axis_tready |=> !skid_v_q && out_v_q,
    "skid did not move to output")
  `V2LC_ASSERT(a_sat_value,
    out_v_q && out_q.sat |-> out_q.x == 16'sh7FFF || out_q.x == 16'sh8000 ||
      out_q.y == 16'sh7FFF || out_q.y == 16'sh8000,
    "saturation flag without a saturated component")

endmodule
